>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/tfvn_pkg.sv
// types and constants of the tileable fractal value noise block
`default_nettype none
package tfvn_pkg;

    localparam int COORD_W   = 11;
    localparam int CORNER_W  = 12;
    localparam int OCT_W     = 4;
    localparam int NUM_OCT   = 16;
    localparam int HASH_W    = 16;
    localparam int SUM_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_OCTAVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_OCTAVE = 2'd1;

    localparam logic [OCT_W-1:0] LOWEST_RESET  = 4'd2;
    localparam logic [OCT_W-1:0] HIGHEST_RESET = 4'd8;

    localparam logic [SUM_W-1:0] HEIGHT_FLOOR = 17'd39424;

    localparam logic [31:0] HASH_X_MUL  = 32'd1619;
    localparam logic [31:0] HASH_Y_MUL  = 32'd31337;
    localparam logic [31:0] HASH_SQ_MUL = 32'd60493;
    localparam logic [31:0] HASH_ADD1   = 32'd19990303;
    localparam logic [31:0] HASH_ADD2   = 32'd1376312589;
    localparam logic [31:0] HASH_MASK   = 32'h7fffffff;
    localparam int          HASH_SHIFT1 = 13;
    localparam int          HASH_SHIFT2 = 15;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } sample_t;

    typedef struct packed {
        logic [SUM_W-1:0] noise_sum;
        logic [SUM_W-1:0] height_fixed;
    } result_t;

endpackage
`default_nettype wire

>>> design/tfvn_hash.sv
// four-stage pipelined lattice corner hash
`default_nettype none
module tfvn_hash (
    input  wire logic                           aclk,
    input  wire logic                           en,
    input  wire logic [tfvn_pkg::CORNER_W-1:0]  cx,
    input  wire logic [tfvn_pkg::CORNER_W-1:0]  cy,
    output logic      [tfvn_pkg::HASH_W-1:0]    hash
);

    logic [31:0] lin;
    logic [31:0] lin_masked;
    logic [31:0] n_a_next, n_a_reg;
    logic [31:0] sq_next, sq_reg;
    logic [31:0] n_b_reg;
    logic [31:0] t_next, t_reg;
    logic [31:0] n_c_reg;
    logic [31:0] u;
    logic [tfvn_pkg::HASH_W-1:0] hash_next, hash_reg;

    // stage a: linear mix and xor fold
    always_comb begin
        lin        = 32'(cx) * tfvn_pkg::HASH_X_MUL + 32'(cy) * tfvn_pkg::HASH_Y_MUL;
        lin_masked = lin & tfvn_pkg::HASH_MASK;
        n_a_next   = lin_masked ^ (lin_masked >> tfvn_pkg::HASH_SHIFT1);
    end

    // stage b: square
    assign sq_next = n_a_reg * n_a_reg;

    // stage c: scale and offset
    assign t_next = sq_reg * tfvn_pkg::HASH_SQ_MUL + tfvn_pkg::HASH_ADD1;

    // stage d: final product
    always_comb begin
        u         = n_c_reg * t_reg + tfvn_pkg::HASH_ADD2;
        hash_next = tfvn_pkg::HASH_W'((u & tfvn_pkg::HASH_MASK) >> tfvn_pkg::HASH_SHIFT2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg  <= n_a_next;
            sq_reg   <= sq_next;
            n_b_reg  <= n_a_reg;
            t_reg    <= t_next;
            n_c_reg  <= n_b_reg;
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule
`default_nettype wire

>>> design/tileable_fractal_value_noise.sv
// top level of the tileable fractal value noise pipeline
`default_nettype none
// One (x_coord, y_coord) word enters per cycle and one result word leaves
// per cycle unless m_ready stalls; m_valid rises when the word reaches the
// last of eight register stages (the accepting edge loads the first). Every
// octave 0..15 has its own lane: four pipelined corner hashes (four stages
// of 32-bit multiply), a bilinear blend in two multiply stages, an
// attenuation shift and a two-level adder tree, so the rate is set by the
// multiplier stages and stays at one word per cycle when not stalled. Lanes
// outside the lowest_octave..highest_octave window add zero. A stall on
// m_ready freezes the whole pipe; s_ready is high whenever the output
// register is empty or being drained. Configuration writes are taken at once
// (cfg_ready is always high) and must only happen while the pipe is empty.
module tileable_fractal_value_noise #(
    parameter int GRID_LOG2 = 11
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tfvn_pkg::sample_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tfvn_pkg::result_t                    m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tfvn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfvn_pkg::OCT_W-1:0]      cfg_data
);

    localparam int STAGES  = 8;  // hash a..d, blend y, blend x, partial sum, final sum
    localparam int XY_DEPTH = 5;
    localparam int GROUPS  = 4;
    localparam int GROUP_N = tfvn_pkg::NUM_OCT / GROUPS;

    // configuration registers
    logic [tfvn_pkg::OCT_W-1:0] lowest_reg, highest_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= tfvn_pkg::LOWEST_RESET;
            highest_reg <= tfvn_pkg::HIGHEST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tfvn_pkg::CFG_LOWEST_OCTAVE:  lowest_reg  <= cfg_data;
                tfvn_pkg::CFG_HIGHEST_OCTAVE: highest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: one enable for every stage
    logic              ce;
    logic [STAGES-1:0] valid_next, valid_reg;

    assign ce         = !valid_reg[STAGES-1] || m_ready;
    assign s_ready    = ce;
    assign valid_next = {valid_reg[STAGES-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    // coordinates ride along for the fraction weights
    tfvn_pkg::sample_t xy_reg [XY_DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            xy_reg[0] <= s_data;
            for (int i = 1; i < XY_DEPTH; i++) begin
                xy_reg[i] <= xy_reg[i-1];
            end
        end
    end

    // attenuated octave terms, one per lane
    logic [tfvn_pkg::HASH_W-1:0] term [tfvn_pkg::NUM_OCT];

    for (genvar k = 0; k < tfvn_pkg::NUM_OCT; k++) begin : g_oct
        localparam logic [31:0] CELLS = (32'd1 << GRID_LOG2) >> k;
        // an octave wider than the grid leaves the mask all ones
        localparam logic [tfvn_pkg::CORNER_W-1:0] MASK =
            tfvn_pkg::CORNER_W'(CELLS - 32'd1);
        localparam logic [15:0] FRAC_MASK = 16'((32'd1 << k) - 32'd1);
        localparam logic [15:0] STEP      = 16'(32'd1 << k);
        localparam logic [tfvn_pkg::OCT_W-1:0] LK = tfvn_pkg::OCT_W'(k);

        logic [tfvn_pkg::CORNER_W-1:0] cx, cy, cx1, cy1;
        logic [tfvn_pkg::HASH_W-1:0]   h00, h10, h11, h01;

        // corner cell coordinates wrapped to the tile
        assign cx  = tfvn_pkg::CORNER_W'(s_data.x_coord >> k);
        assign cy  = tfvn_pkg::CORNER_W'(s_data.y_coord >> k);
        assign cx1 = cx + 1'b1;
        assign cy1 = cy + 1'b1;

        tfvn_hash u_h00 (.aclk(aclk), .en(ce), .cx(cx & MASK),  .cy(cy & MASK),  .hash(h00));
        tfvn_hash u_h10 (.aclk(aclk), .en(ce), .cx(cx1 & MASK), .cy(cy & MASK),  .hash(h10));
        tfvn_hash u_h11 (.aclk(aclk), .en(ce), .cx(cx1 & MASK), .cy(cy1 & MASK), .hash(h11));
        tfvn_hash u_h01 (.aclk(aclk), .en(ce), .cx(cx & MASK),  .cy(cy1 & MASK), .hash(h01));

        // blend along y
        logic [15:0] fy, wfy;
        logic [31:0] left_next, left_reg, right_next, right_reg;

        assign fy         = 16'(xy_reg[3].y_coord) & FRAC_MASK;
        assign wfy        = STEP - fy;
        assign left_next  = 32'(fy) * 32'(h01) + 32'(wfy) * 32'(h00);
        assign right_next = 32'(fy) * 32'(h11) + 32'(wfy) * 32'(h10);

        // blend along x, then scale back by the cell area
        logic [15:0] fx, wfx;
        logic [47:0] blend;
        logic [tfvn_pkg::HASH_W-1:0] oct_next, oct_reg;

        assign fx       = 16'(xy_reg[4].x_coord) & FRAC_MASK;
        assign wfx      = STEP - fx;
        assign blend    = 48'(right_reg) * 48'(fx) + 48'(left_reg) * 48'(wfx);
        assign oct_next = tfvn_pkg::HASH_W'(blend >> (2 * k));

        always_ff @(posedge aclk) begin
            if (ce) begin
                left_reg  <= left_next;
                right_reg <= right_next;
                oct_reg   <= oct_next;
            end
        end

        // octaves outside the window contribute nothing
        logic active;
        assign active  = (lowest_reg <= LK) && (LK <= highest_reg);
        assign term[k] = active ? (oct_reg >> (highest_reg - LK)) : '0;
    end

    // first adder level: groups of four lanes
    logic [17:0] part_next [GROUPS];
    logic [17:0] part_reg  [GROUPS];

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            part_next[g] = '0;
            for (int j = 0; j < GROUP_N; j++) begin
                part_next[g] = part_next[g] + 18'(term[g*GROUP_N + j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int g = 0; g < GROUPS; g++) begin
                part_reg[g] <= part_next[g];
            end
        end
    end

    // final sum, wrap to 17 bits, clamp the height floor
    logic [19:0]                total;
    logic [tfvn_pkg::SUM_W-1:0] sum17;
    tfvn_pkg::result_t          out_next, out_reg;

    always_comb begin
        total = 20'(part_reg[0]) + 20'(part_reg[1]) + 20'(part_reg[2]) + 20'(part_reg[3]);
        sum17 = total[tfvn_pkg::SUM_W-1:0];
        out_next.noise_sum    = sum17;
        out_next.height_fixed = (sum17 < tfvn_pkg::HEIGHT_FLOOR) ?
                                tfvn_pkg::HEIGHT_FLOOR : sum17;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = valid_reg[STAGES-1];
    assign m_data  = out_reg;

endmodule
`default_nettype wire

>>> design/tfvn_checker.sv
// port-level checker for the value noise block and its bind
`default_nettype none
`include "assert_macros.svh"
module tfvn_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire tfvn_pkg::result_t               m_data
);

    // a held result word stays put
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // height never drops below the floor
    `ASSERT_IMPLY(a_height_floor, aclk, aresetn, m_valid, m_data.height_fixed >= tfvn_pkg::HEIGHT_FLOOR)

    // height is the sum when the sum is at or above the floor
    `ASSERT_IMPLY(a_height_sum, aclk, aresetn, m_valid && (m_data.noise_sum >= tfvn_pkg::HEIGHT_FLOOR), m_data.height_fixed == m_data.noise_sum)

    // an empty output side never blocks the input
    `ASSERT_IMPLY(a_ready_empty, aclk, aresetn, !m_valid, s_ready)

endmodule

bind tileable_fractal_value_noise tfvn_checker u_tfvn_checker (.*);
`default_nettype wire
